// ===== sv/mps_pkg.sv =====
package mps_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int LEVEL_W         = 10;
  localparam int TIME_W          = 32;
  localparam int DUR_W           = 16;
  localparam int CNT_W           = 16;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_IDX_W       = 3;

  // fixed level at or above which soil counts as properly dry
  localparam int DRY_LEVEL = 600;

  localparam logic [DUR_W-1:0]   PUMP_DURATION_RST = DUR_W'(10000);
  localparam logic [LEVEL_W-1:0] DRY_THRESHOLD_RST = LEVEL_W'(320);
  localparam logic [LEVEL_W-1:0] WET_THRESHOLD_RST = LEVEL_W'(250);
  localparam logic [TIME_W-1:0]  MIN_INTERVAL_RST  = TIME_W'(14400000);
  localparam logic [TIME_W-1:0]  MAX_IDLE_RST      = TIME_W'(172800000);
  localparam logic [TIME_W-1:0]  CHECK_INTERVAL_RST   = TIME_W'(300000);
  localparam logic [TIME_W-1:0]  RECHECK_INTERVAL_RST = TIME_W'(1000);
  localparam logic [LEVEL_W-1:0] DISCONNECT_RST    = LEVEL_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PUMP_DURATION    = 3'd0,
    REG_DRY_THRESHOLD    = 3'd1,
    REG_WET_THRESHOLD    = 3'd2,
    REG_MIN_INTERVAL     = 3'd3,
    REG_MAX_IDLE         = 3'd4,
    REG_CHECK_INTERVAL   = 3'd5,
    REG_RECHECK_INTERVAL = 3'd6,
    REG_DISCONNECT_LEVEL = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_HELD      = 3'd0,
    ACT_PUMPING   = 3'd1,
    ACT_STOPPED   = 3'd2,
    ACT_NO_NEED   = 3'd3,
    ACT_CAUTIOUS  = 3'd4,
    ACT_DRY_START = 3'd5,
    ACT_TOO_SOON  = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    SOIL_WATER        = 3'd0,
    SOIL_HUMID        = 3'd1,
    SOIL_DRYISH       = 3'd2,
    SOIL_DRY          = 3'd3,
    SOIL_DISCONNECTED = 3'd4,
    SOIL_NONE         = 3'd5
  } soil_t;

  typedef struct packed {
    logic [DUR_W-1:0]   pump_duration_ms;
    logic [LEVEL_W-1:0] dry_threshold;
    logic [LEVEL_W-1:0] wet_threshold;
    logic [TIME_W-1:0]  min_interval_ms;
    logic [TIME_W-1:0]  max_idle_ms;
    logic [TIME_W-1:0]  check_interval_ms;
    logic [TIME_W-1:0]  recheck_interval_ms;
    logic [LEVEL_W-1:0] disconnect_level;
  } cfg_t;

  typedef struct packed {
    logic             pump_on;
    action_t          action;
    soil_t            soil_class;
    logic [CNT_W-1:0] normal_starts;
    logic [CNT_W-1:0] cautious_starts;
  } res_t;

endpackage

// ===== sv/moisture_pump_scheduler.sv =====
// Moisture pump scheduler.
// Input channel (in_valid/in_ready) carries one poll per transaction: the
// millisecond time now_ms and an ADC moisture_sample. Output channel
// (out_valid/out_ready) returns exactly one result per poll: pump_on, action,
// soil_class and the two start counters after that poll.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), one
// register per cycle, to be used only while no poll is in flight.
// Timing: a poll accepted into the input register is decided and lands in the
// output register when it advances, once the output register is empty or being
// drained. Throughput is one poll per cycle while the receiver does not stall;
// the per-poll decision is a single pass of 32-bit compares and adds between the
// two registers, with the scheduler state updated in the same edge.
// Reset (rst, synchronous) loads the register defaults and clears the state
// and both pipeline valids.
// When the receiver stalls, the output register holds its result and the
// input register still takes one further poll; in_ready then drops until the
// output register drains.
module moisture_pump_scheduler #(
  parameter int SAMPLE_BITS = mps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mps_pkg::TIME_W-1:0]         now_ms,
  input  logic [SAMPLE_BITS-1:0]             moisture_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               pump_on,
  output logic [2:0]                         action,
  output logic [2:0]                         soil_class,
  output logic [mps_pkg::CNT_W-1:0]          normal_starts,
  output logic [mps_pkg::CNT_W-1:0]          cautious_starts,
  input  logic                               cfg_we,
  input  logic [mps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mps_pkg::cfg_t cfg;

  logic                       s1_valid;
  logic [mps_pkg::TIME_W-1:0] s1_now;
  logic [SAMPLE_BITS-1:0]     s1_sample;
  logic                       adv;

  mps_pkg::soil_t soil;
  logic           need;
  mps_pkg::res_t  res, res_q;
  logic           out_valid_q;

  assign adv      = s1_valid && (!out_valid_q || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now    <= now_ms;
      s1_sample <= moisture_sample;
    end
  end

  mps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mps_classify #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_classify (
    .sample (s1_sample),
    .cfg    (cfg),
    .soil   (soil),
    .need   (need)
  );

  mps_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (adv),
    .now  (s1_now),
    .soil (soil),
    .need (need),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid       = out_valid_q;
  assign pump_on         = res_q.pump_on;
  assign action          = res_q.action;
  assign soil_class      = res_q.soil_class;
  assign normal_starts   = res_q.normal_starts;
  assign cautious_starts = res_q.cautious_starts;

  // a poll waiting in the input register is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid)
    else $error("input transaction lost while stalled");

  // soil is only classified when the pump is idle and not held off
  a_soil_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_q.action == mps_pkg::ACT_HELD || res_q.action == mps_pkg::ACT_PUMPING ||
                  res_q.action == mps_pkg::ACT_STOPPED)
    |-> res_q.soil_class == mps_pkg::SOIL_NONE)
    else $error("soil class reported on a poll that did not sample");

  // a stop leaves the pump off, a start leaves it on
  a_pump_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_q.action != mps_pkg::ACT_STOPPED || !res_q.pump_on) &&
                  (res_q.action != mps_pkg::ACT_DRY_START || res_q.pump_on) &&
                  (res_q.action != mps_pkg::ACT_CAUTIOUS || res_q.pump_on))
    else $error("pump drive disagrees with action");

  // a dry start advances the normal counter by exactly one
  a_normal_cnt: assert property (@(posedge clk) disable iff (rst)
    adv && res.action == mps_pkg::ACT_DRY_START |=>
      normal_starts == $past(u_core.normal_count) + 1'b1)
    else $error("normal start count not advanced");

endmodule

// ===== sv/mps_cfg.sv =====
module mps_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output mps_pkg::cfg_t                      cfg
);

  mps_pkg::cfg_t    regs;
  mps_pkg::cfg_idx_t idx;

  assign idx = mps_pkg::cfg_idx_t'(cfg_index);
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pump_duration_ms    <= mps_pkg::PUMP_DURATION_RST;
      regs.dry_threshold       <= mps_pkg::DRY_THRESHOLD_RST;
      regs.wet_threshold       <= mps_pkg::WET_THRESHOLD_RST;
      regs.min_interval_ms     <= mps_pkg::MIN_INTERVAL_RST;
      regs.max_idle_ms         <= mps_pkg::MAX_IDLE_RST;
      regs.check_interval_ms   <= mps_pkg::CHECK_INTERVAL_RST;
      regs.recheck_interval_ms <= mps_pkg::RECHECK_INTERVAL_RST;
      regs.disconnect_level    <= mps_pkg::DISCONNECT_RST;
    end else if (cfg_we) begin
      unique case (idx)
        mps_pkg::REG_PUMP_DURATION:
          regs.pump_duration_ms <= cfg_data[mps_pkg::DUR_W-1:0];
        mps_pkg::REG_DRY_THRESHOLD:
          regs.dry_threshold <= cfg_data[mps_pkg::LEVEL_W-1:0];
        mps_pkg::REG_WET_THRESHOLD:
          regs.wet_threshold <= cfg_data[mps_pkg::LEVEL_W-1:0];
        mps_pkg::REG_MIN_INTERVAL:
          regs.min_interval_ms <= cfg_data[mps_pkg::TIME_W-1:0];
        mps_pkg::REG_MAX_IDLE:
          regs.max_idle_ms <= cfg_data[mps_pkg::TIME_W-1:0];
        mps_pkg::REG_CHECK_INTERVAL:
          regs.check_interval_ms <= cfg_data[mps_pkg::TIME_W-1:0];
        mps_pkg::REG_RECHECK_INTERVAL:
          regs.recheck_interval_ms <= cfg_data[mps_pkg::TIME_W-1:0];
        mps_pkg::REG_DISCONNECT_LEVEL:
          regs.disconnect_level <= cfg_data[mps_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/mps_classify.sv =====
module mps_classify #(
  parameter int SAMPLE_BITS = mps_pkg::SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0] sample,
  input  mps_pkg::cfg_t          cfg,
  output mps_pkg::soil_t         soil,
  output logic                   need
);

  localparam int CMP_W = (SAMPLE_BITS > mps_pkg::LEVEL_W) ? SAMPLE_BITS : mps_pkg::LEVEL_W;

  logic [CMP_W-1:0] s, disc, dry_thr, wet_thr, dry_lvl;
  logic             is_disc, over_dry_thr;

  assign s       = CMP_W'(sample);
  assign disc    = CMP_W'(cfg.disconnect_level);
  assign dry_thr = CMP_W'(cfg.dry_threshold);
  assign wet_thr = CMP_W'(cfg.wet_threshold);
  assign dry_lvl = CMP_W'(mps_pkg::DRY_LEVEL);

  assign is_disc      = (s >= disc);
  assign over_dry_thr = (s >= dry_thr);
  assign need         = !is_disc && over_dry_thr;

  // priority: disconnected, dry, dryish, humid, water
  always_comb begin
    if (is_disc)           soil = mps_pkg::SOIL_DISCONNECTED;
    else if (s >= dry_lvl) soil = mps_pkg::SOIL_DRY;
    else if (over_dry_thr) soil = mps_pkg::SOIL_DRYISH;
    else if (s > wet_thr)  soil = mps_pkg::SOIL_HUMID;
    else                   soil = mps_pkg::SOIL_WATER;
  end

endmodule

// ===== sv/mps_core.sv =====
module mps_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [mps_pkg::TIME_W-1:0]    now,
  input  mps_pkg::soil_t                soil,
  input  logic                          need,
  input  mps_pkg::cfg_t                 cfg,
  output mps_pkg::res_t                 res
);

  logic [mps_pkg::TIME_W-1:0] hold_until, hold_until_next;
  logic [mps_pkg::TIME_W-1:0] last_start, last_start_next;
  logic [mps_pkg::TIME_W-1:0] first_time;
  logic                       pumping, pumping_next;
  logic                       started;
  logic [mps_pkg::CNT_W-1:0]  normal_count, normal_count_next;
  logic [mps_pkg::CNT_W-1:0]  cautious_count, cautious_count_next;

  logic [mps_pkg::TIME_W-1:0] first_eff, since_start, since_first;
  logic [mps_pkg::TIME_W-1:0] check_at, recheck_at;
  mps_pkg::action_t           action;
  mps_pkg::soil_t             soil_out;

  // the first transaction supplies its own time as the start reference
  assign first_eff   = started ? first_time : now;
  assign since_start = now - last_start;
  assign since_first = now - first_eff;
  assign check_at    = now + cfg.check_interval_ms;
  assign recheck_at  = now + cfg.recheck_interval_ms;

  always_comb begin
    hold_until_next     = hold_until;
    last_start_next     = last_start;
    pumping_next        = pumping;
    normal_count_next   = normal_count;
    cautious_count_next = cautious_count;
    soil_out            = mps_pkg::SOIL_NONE;
    action              = mps_pkg::ACT_HELD;
    if (hold_until > now) begin
      action = mps_pkg::ACT_HELD;
    end else if (pumping) begin
      if (since_start > mps_pkg::TIME_W'(cfg.pump_duration_ms)) begin
        pumping_next    = 1'b0;
        hold_until_next = check_at;
        action          = mps_pkg::ACT_STOPPED;
      end else begin
        hold_until_next = recheck_at;
        action          = mps_pkg::ACT_PUMPING;
      end
    end else begin
      soil_out = soil;
      if (!need) begin
        if (since_start > cfg.max_idle_ms && since_first > cfg.max_idle_ms) begin
          cautious_count_next = cautious_count + 1'b1;
          pumping_next        = 1'b1;
          last_start_next     = now;
          action              = mps_pkg::ACT_CAUTIOUS;
        end else begin
          hold_until_next = check_at;
          action          = mps_pkg::ACT_NO_NEED;
        end
      end else if (last_start == '0 || since_start > cfg.min_interval_ms) begin
        // a start at time zero reads back as never started
        normal_count_next = normal_count + 1'b1;
        pumping_next      = 1'b1;
        last_start_next   = now;
        action            = mps_pkg::ACT_DRY_START;
      end else begin
        hold_until_next = check_at;
        action          = mps_pkg::ACT_TOO_SOON;
      end
    end
  end

  assign res.pump_on         = pumping_next;
  assign res.action          = action;
  assign res.soil_class      = soil_out;
  assign res.normal_starts   = normal_count_next;
  assign res.cautious_starts = cautious_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_until     <= '0;
      last_start     <= '0;
      first_time     <= '0;
      pumping        <= 1'b0;
      started        <= 1'b0;
      normal_count   <= '0;
      cautious_count <= '0;
    end else if (take) begin
      hold_until     <= hold_until_next;
      last_start     <= last_start_next;
      first_time     <= first_eff;
      pumping        <= pumping_next;
      started        <= 1'b1;
      normal_count   <= normal_count_next;
      cautious_count <= cautious_count_next;
    end
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;

  localparam int SW          = mps_pkg::SAMPLE_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [mps_pkg::TIME_W-1:0] now;
    logic [SW-1:0]              sample;
  } poll_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic [mps_pkg::TIME_W-1:0]     now_ms;
  logic [SW-1:0]                  moisture_sample;
  logic                           out_valid;
  logic                           out_ready;
  logic                           pump_on;
  logic [2:0]                     action;
  logic [2:0]                     soil_class;
  logic [mps_pkg::CNT_W-1:0]      normal_starts;
  logic [mps_pkg::CNT_W-1:0]      cautious_starts;
  logic                           cfg_we;
  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mps_pkg::CFG_DATA_W-1:0] cfg_data;

  moisture_pump_scheduler u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .now_ms          (now_ms),
    .moisture_sample (moisture_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pump_on         (pump_on),
    .action          (action),
    .soil_class      (soil_class),
    .normal_starts   (normal_starts),
    .cautious_starts (cautious_starts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // register copy and scheduler state as the block should hold them
  mps_pkg::cfg_t reg_copy = '{mps_pkg::PUMP_DURATION_RST, mps_pkg::DRY_THRESHOLD_RST,
                              mps_pkg::WET_THRESHOLD_RST, mps_pkg::MIN_INTERVAL_RST,
                              mps_pkg::MAX_IDLE_RST, mps_pkg::CHECK_INTERVAL_RST,
                              mps_pkg::RECHECK_INTERVAL_RST, mps_pkg::DISCONNECT_RST};
  logic [mps_pkg::TIME_W-1:0] hold_until_ms  = '0;
  logic [mps_pkg::TIME_W-1:0] pump_start_ms  = '0;
  logic [mps_pkg::TIME_W-1:0] first_poll_ms  = '0;
  logic                       pump_running   = 1'b0;
  logic                       seen_first     = 1'b0;
  logic [mps_pkg::CNT_W-1:0]  normal_total   = '0;
  logic [mps_pkg::CNT_W-1:0]  cautious_total = '0;

  poll_t         polls_to_send[$];
  mps_pkg::res_t poll_results_due[$];

  int                         mismatches    = 0;
  int                         send_gap      = 0;
  int                         stall_left    = 0;
  int                         cycle_count   = 0;
  logic                       calm          = 1'b0;
  logic                       long_hold_req = 1'b0;
  logic [mps_pkg::TIME_W-1:0] clock_ms      = '0;

  function automatic mps_pkg::res_t decide_poll(input logic [mps_pkg::TIME_W-1:0] now,
                                                input logic [SW-1:0] s);
    mps_pkg::res_t r;
    logic dry_enough;
    r.action     = mps_pkg::ACT_HELD;
    r.soil_class = mps_pkg::SOIL_NONE;
    if (!seen_first) begin
      seen_first    = 1'b1;
      first_poll_ms = now;
    end
    // deadline compare is plain unsigned, no wrap handling
    if (hold_until_ms > now) begin
      r.action = mps_pkg::ACT_HELD;
    end else if (pump_running) begin
      if (now - pump_start_ms > mps_pkg::TIME_W'(reg_copy.pump_duration_ms)) begin
        pump_running  = 1'b0;
        hold_until_ms = now + reg_copy.check_interval_ms;
        r.action      = mps_pkg::ACT_STOPPED;
      end else begin
        hold_until_ms = now + reg_copy.recheck_interval_ms;
        r.action      = mps_pkg::ACT_PUMPING;
      end
    end else begin
      dry_enough = (s < reg_copy.disconnect_level) && (s >= reg_copy.dry_threshold);
      if (s >= reg_copy.disconnect_level)   r.soil_class = mps_pkg::SOIL_DISCONNECTED;
      else if (s >= mps_pkg::DRY_LEVEL)     r.soil_class = mps_pkg::SOIL_DRY;
      else if (s >= reg_copy.dry_threshold) r.soil_class = mps_pkg::SOIL_DRYISH;
      else if (s > reg_copy.wet_threshold)  r.soil_class = mps_pkg::SOIL_HUMID;
      else                                  r.soil_class = mps_pkg::SOIL_WATER;
      if (!dry_enough) begin
        if (now - pump_start_ms > reg_copy.max_idle_ms &&
            now - first_poll_ms > reg_copy.max_idle_ms) begin
          cautious_total = cautious_total + 1'b1;
          pump_running   = 1'b1;
          pump_start_ms  = now;
          r.action       = mps_pkg::ACT_CAUTIOUS;
        end else begin
          hold_until_ms = now + reg_copy.check_interval_ms;
          r.action      = mps_pkg::ACT_NO_NEED;
        end
      end else if (pump_start_ms == '0 ||
                   now - pump_start_ms > reg_copy.min_interval_ms) begin
        // a start at time zero still reads as never started
        normal_total  = normal_total + 1'b1;
        pump_running  = 1'b1;
        pump_start_ms = now;
        r.action      = mps_pkg::ACT_DRY_START;
      end else begin
        hold_until_ms = now + reg_copy.check_interval_ms;
        r.action      = mps_pkg::ACT_TOO_SOON;
      end
    end
    r.pump_on         = pump_running;
    r.normal_starts   = normal_total;
    r.cautious_starts = cautious_total;
    return r;
  endfunction

  function automatic logic [SW-1:0] sample_near(input int centre);
    int v;
    v = centre + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    else if (v > 1023) v = 1023;
    return v[SW-1:0];
  endfunction

  task automatic add_poll(input logic [mps_pkg::TIME_W-1:0] t, input logic [SW-1:0] s);
    poll_t p;
    p.now    = t;
    p.sample = s;
    polls_to_send.push_back(p);
  endtask

  task automatic queue_random(input int n, input int step);
    int r;
    logic [SW-1:0] s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 82)      clock_ms += $urandom_range(0, step);
      else if (r < 92) clock_ms += $urandom_range(0, step * 40);
      else if (r < 96) clock_ms = $urandom();
      else if (r < 98) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, step * 4);
      else             clock_ms -= $urandom_range(0, step * 4);
      r = $urandom_range(0, 99);
      if (r < 40)      s = SW'($urandom_range(0, 1023));
      else if (r < 65) s = sample_near(reg_copy.dry_threshold);
      else if (r < 80) s = sample_near(reg_copy.disconnect_level);
      else if (r < 90) s = sample_near(reg_copy.wet_threshold);
      else             s = sample_near(mps_pkg::DRY_LEVEL);
      add_poll(clock_ms, s);
    end
  endtask

  task automatic write_reg(input mps_pkg::cfg_idx_t idx,
                           input logic [mps_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      mps_pkg::REG_PUMP_DURATION:
        reg_copy.pump_duration_ms = val[mps_pkg::DUR_W-1:0];
      mps_pkg::REG_DRY_THRESHOLD:
        reg_copy.dry_threshold = val[mps_pkg::LEVEL_W-1:0];
      mps_pkg::REG_WET_THRESHOLD:
        reg_copy.wet_threshold = val[mps_pkg::LEVEL_W-1:0];
      mps_pkg::REG_MIN_INTERVAL:     reg_copy.min_interval_ms     = val;
      mps_pkg::REG_MAX_IDLE:         reg_copy.max_idle_ms         = val;
      mps_pkg::REG_CHECK_INTERVAL:   reg_copy.check_interval_ms   = val;
      mps_pkg::REG_RECHECK_INTERVAL: reg_copy.recheck_interval_ms = val;
      mps_pkg::REG_DISCONNECT_LEVEL:
        reg_copy.disconnect_level = val[mps_pkg::LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [mps_pkg::DUR_W-1:0] dur,
                              input logic [mps_pkg::LEVEL_W-1:0] dry, wet,
                              input logic [mps_pkg::TIME_W-1:0] min_gap, idle, chk, rechk,
                              input logic [mps_pkg::LEVEL_W-1:0] disc);
    write_reg(mps_pkg::REG_PUMP_DURATION, mps_pkg::CFG_DATA_W'(dur));
    write_reg(mps_pkg::REG_DRY_THRESHOLD, mps_pkg::CFG_DATA_W'(dry));
    write_reg(mps_pkg::REG_WET_THRESHOLD, mps_pkg::CFG_DATA_W'(wet));
    write_reg(mps_pkg::REG_MIN_INTERVAL, min_gap);
    write_reg(mps_pkg::REG_MAX_IDLE, idle);
    write_reg(mps_pkg::REG_CHECK_INTERVAL, chk);
    write_reg(mps_pkg::REG_RECHECK_INTERVAL, rechk);
    write_reg(mps_pkg::REG_DISCONNECT_LEVEL, mps_pkg::CFG_DATA_W'(disc));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // sender holds back until every transaction has come out the far side
  task automatic drain();
    while (polls_to_send.size() != 0 || in_valid || poll_results_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("moisture_pump_scheduler verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_polls
    poll_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (polls_to_send.size() != 0) begin
        p = polls_to_send.pop_front();
        in_valid        <= 1'b1;
        now_ms          <= p.now;
        moisture_sample <= p.sample;
        if (!calm && $urandom_range(0, 99) < 6) send_gap <= $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      stall_left    <= 79;
      out_ready     <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 7) begin
      stall_left <= $urandom_range(0, 8);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // results are checked before the poll taken at the same edge is predicted
  always @(posedge clk) begin : watch_results
    mps_pkg::res_t due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (poll_results_due.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result: pump_on=%0b action=%0d soil=%0d %s=%0d %s=%0d",
                     pump_on, action, soil_class, "normal", normal_starts,
                     "cautious", cautious_starts);
        end else begin
          due = poll_results_due.pop_front();
          if (pump_on !== due.pump_on || action !== due.action ||
              soil_class !== due.soil_class || normal_starts !== due.normal_starts ||
              cautious_starts !== due.cautious_starts) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("mismatch: exp pump_on=%0b action=%0d soil=%0d normal=%0d cautious=%0d",
                       due.pump_on, due.action, due.soil_class, due.normal_starts,
                       due.cautious_starts);
              $display("          got pump_on=%0b action=%0d soil=%0d normal=%0d cautious=%0d",
                       pump_on, action, soil_class, normal_starts, cautious_starts);
            end
          end
        end
      end
      if (in_valid && in_ready)
        poll_results_due.push_back(decide_poll(now_ms, moisture_sample));
    end
  end

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    now_ms          = '0;
    moisture_sample = '0;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = mps_pkg::REG_PUMP_DURATION;
    cfg_data        = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default registers: first poll at zero, every action, deadline wrap
    add_poll(32'd0, 10'd700);
    add_poll(32'd3, 10'd0);
    add_poll(32'd500, 10'd1023);
    add_poll(32'd10001, 10'd0);
    add_poll(32'd310001, 10'd400);
    add_poll(32'd320002, 10'd0);
    add_poll(32'd620002, 10'd500);
    add_poll(32'd920002, 10'd100);
    add_poll(32'hFFFF_FF00, 10'd1000);
    add_poll(32'hFFFF_FFFF, 10'd300);
    add_poll(32'd10240, 10'd0);
    add_poll(32'd310240, 10'd260);
    drain();

    // odd thresholds: everything below the top counts as dry enough
    program_regs(16'd5, 10'd0, 10'd1023, 32'd0, 32'hFFFF_FFFF, 32'd10, 32'd2, 10'd1023);
    add_poll(32'd700000, 10'd0);
    add_poll(32'd700003, 10'd1023);
    add_poll(32'd700006, 10'd1023);
    add_poll(32'd700016, 10'd1023);
    add_poll(32'd700026, 10'd700);
    add_poll(32'd700040, 10'd512);
    drain();

    clock_ms = 32'd800000;
    program_regs(16'd20, 10'd320, 10'd250, 32'd100, 32'd300, 32'd50, 32'd5, 10'd1000);
    queue_random(250, 12);
    long_hold_req = 1'b1;
    drain();

    program_regs(16'd200, 10'd600, 10'd100, 32'd3000, 32'd1500, 32'd40, 32'd17, 10'd900);
    queue_random(250, 30);
    drain();

    program_regs(16'd0, 10'd0, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0, 10'd0);
    queue_random(250, 3);
    drain();

    program_regs(16'hFFFF, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023);
    queue_random(250, 5000);
    drain();

    program_regs(16'd1000, 10'd500, 10'd700, 32'd8000, 32'd20000, 32'd300, 32'd50, 10'd650);
    queue_random(250, 200);
    drain();

    // closing stretch runs back to back on both sides
    calm = 1'b1;
    program_regs(16'd30, 10'd320, 10'd250, 32'd150, 32'd400, 32'd60, 32'd8, 10'd1000);
    queue_random(250, 15);
    drain();

    if (mismatches == 0 && poll_results_due.size() == 0)
      $display("moisture_pump_scheduler verification clean");
    else
      $display("moisture_pump_scheduler verification failed");
    $finish;
  end

endmodule

// ===== moisture_pump_scheduler.f =====
sv/mps_pkg.sv
sv/mps_cfg.sv
sv/mps_classify.sv
sv/mps_core.sv
sv/moisture_pump_scheduler.sv
verif/testbench.sv
